FILE: sv/ising_pkg.sv
package ising_pkg;

   // Lattice geometry (side is a power of two so row and column wrap by truncation)
   localparam int SIDE_W = 6;
   localparam int SIDE   = 1 << SIDE_W;
   localparam int SITES  = SIDE * SIDE;
   localparam int ADDR_W = 2 * SIDE_W;

   // Field widths
   localparam int RND_W  = 16;
   localparam int CFG_W  = 17;
   localparam int MAG_W  = 14;
   localparam int SUM_W  = 48;
   localparam int IDX_W  = 2;

   // Item kinds
   localparam logic KIND_INIT   = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   // Register indexes
   localparam logic [IDX_W-1:0] CSR_INIT_DOWN    = 2'd0;
   localparam logic [IDX_W-1:0] CSR_ACCEPT_FOUR  = 2'd1;
   localparam logic [IDX_W-1:0] CSR_ACCEPT_EIGHT = 2'd2;

   // Register reset values
   localparam logic [CFG_W-1:0] INIT_DOWN_RESET    = 17'd32768;
   localparam logic [CFG_W-1:0] ACCEPT_FOUR_RESET  = 17'd1200;
   localparam logic [CFG_W-1:0] ACCEPT_EIGHT_RESET = 17'd22;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_RD_A,
      S_RD_B,
      S_RD_C,
      S_EVAL
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;           // capture the accepted item
      logic read_a;         // read center and upper neighbor
      logic read_b;         // read lower and left neighbors
      logic read_c;         // read right neighbor
      logic commit_init;    // write the init site, load result
      logic commit_update;  // decide flip, write back, load result
   } dp_cmd_type;

endpackage

FILE: sv/ising_ram.sv
module ising_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic                     rd_en_b,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read ports, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en_a) begin
         rd_a_ff <= mem_ff[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: sv/ising_ctrl.sv
module ising_ctrl
   import ising_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       req_kind,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // Result slot can take a new item when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = (req_kind == KIND_UPDATE) ? S_RD_A : S_INIT;
            end
         end
         S_INIT: begin
            if (out_free) begin
               cmd.commit_init = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_RD_A: begin
            cmd.read_a = 1'b1;
            state_in   = S_RD_B;
         end
         S_RD_B: begin
            cmd.read_b = 1'b1;
            state_in   = S_RD_C;
         end
         S_RD_C: begin
            cmd.read_c = 1'b1;
            state_in   = S_EVAL;
         end
         S_EVAL: begin
            if (out_free) begin
               cmd.commit_update = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result valid: set on commit, drop when taken
   always_comb begin
      if (cmd.commit_init || cmd.commit_update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: sv/ising_dp.sv
module ising_dp
   import ising_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  dp_cmd_type       cmd,
   input  logic [31:0]      req_tdata,
   output logic [63:0]      rsp_tdata,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0] csr_data
);

   logic [SIDE_W-1:0]       row_ff;
   logic [SIDE_W-1:0]       col_ff;
   logic [RND_W-1:0]        rnd_ff;
   logic                    center_ff;
   logic                    up_ff;
   logic                    down_ff;
   logic                    left_ff;
   logic [CFG_W-1:0]        init_down_ff;
   logic [CFG_W-1:0]        accept_four_ff;
   logic [CFG_W-1:0]        accept_eight_ff;
   logic signed [MAG_W-1:0] mag_ff;
   logic signed [MAG_W-1:0] mag_in;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_in;
   logic [63:0]             rsp_data_ff;

   logic                    ram_we;
   logic                    ram_wdata;
   logic                    ram_re_a;
   logic                    ram_re_b;
   logic [ADDR_W-1:0]       site_addr;
   logic [ADDR_W-1:0]       addr_a;
   logic [ADDR_W-1:0]       addr_b;
   logic                    rdata_a;
   logic                    rdata_b;

   logic [2:0]              aligned;
   logic [CFG_W-1:0]        rnd_ext;
   logic                    init_spin;
   logic                    accept;
   logic                    spin_after;
   logic signed [MAG_W-1:0] mag_delta;

   // Configuration registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_down_ff    <= INIT_DOWN_RESET;
         accept_four_ff  <= ACCEPT_FOUR_RESET;
         accept_eight_ff <= ACCEPT_EIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_INIT_DOWN:    init_down_ff    <= csr_data;
            CSR_ACCEPT_FOUR:  accept_four_ff  <= csr_data;
            CSR_ACCEPT_EIGHT: accept_eight_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_ff <= req_tdata[SIDE_W-1:0];
         col_ff <= req_tdata[2*SIDE_W-1:SIDE_W];
         rnd_ff <= req_tdata[2*SIDE_W+RND_W-1:2*SIDE_W];
      end
   end

   // Neighbor addresses wrap by truncation
   assign site_addr = {row_ff, col_ff};

   always_comb begin
      addr_a = site_addr;
      addr_b = {row_ff - 1'b1, col_ff};
      if (cmd.read_b) begin
         addr_a = {row_ff + 1'b1, col_ff};
         addr_b = {row_ff, col_ff - 1'b1};
      end else if (cmd.read_c) begin
         addr_a = {row_ff, col_ff + 1'b1};
      end
   end

   assign ram_re_a = cmd.read_a || cmd.read_b || cmd.read_c;
   assign ram_re_b = cmd.read_a || cmd.read_b;

   // Hold center and three neighbors; the right one stays on port a
   always_ff @(posedge clock) begin
      if (cmd.read_b) begin
         center_ff <= rdata_a;
         up_ff     <= rdata_b;
      end
      if (cmd.read_c) begin
         down_ff <= rdata_a;
         left_ff <= rdata_b;
      end
   end

   // Count neighbors parallel to the center spin
   assign aligned = 3'(!(up_ff ^ center_ff)) + 3'(!(down_ff ^ center_ff))
                  + 3'(!(left_ff ^ center_ff)) + 3'(!(rdata_a ^ center_ff));

   assign rnd_ext   = {1'b0, rnd_ff};
   assign init_spin = !(rnd_ext < init_down_ff);

   // Metropolis decision: two or fewer aligned means energy change not positive
   always_comb begin
      case (aligned)
         3'd3:    accept = rnd_ext < accept_four_ff;
         3'd4:    accept = rnd_ext < accept_eight_ff;
         default: accept = 1'b1;
      endcase
   end

   // Spin write-back and magnetization step
   always_comb begin
      ram_we     = 1'b0;
      ram_wdata  = init_spin;
      spin_after = init_spin;
      mag_delta  = '0;
      if (cmd.commit_init) begin
         ram_we    = 1'b1;
         mag_delta = init_spin ? MAG_W'(1) : -MAG_W'(1);
      end else if (cmd.commit_update) begin
         ram_we     = accept;
         ram_wdata  = !center_ff;
         spin_after = accept ? !center_ff : center_ff;
         if (accept) begin
            mag_delta = center_ff ? -MAG_W'(2) : MAG_W'(2);
         end
      end
   end

   assign mag_in = mag_ff + mag_delta;
   assign sum_in = sum_ff + {{(SUM_W-MAG_W){mag_in[MAG_W-1]}}, mag_in};

   // Running totals
   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff <= '0;
         sum_ff <= '0;
      end else if (cmd.commit_init) begin
         mag_ff <= mag_in;
      end else if (cmd.commit_update) begin
         mag_ff <= mag_in;
         sum_ff <= sum_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.commit_init) begin
         rsp_data_ff <= {sum_ff, mag_in, 1'b0, spin_after};
      end else if (cmd.commit_update) begin
         rsp_data_ff <= {sum_in, mag_in, accept, spin_after};
      end
   end

   assign rsp_tdata = rsp_data_ff;

   ising_ram #(
      .WIDTH(1),
      .DEPTH(SITES)
   ) u_lattice (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (site_addr),
      .wr_data   (ram_wdata),
      .rd_en_a   (ram_re_a),
      .rd_addr_a (addr_a),
      .rd_data_a (rdata_a),
      .rd_en_b   (ram_re_b),
      .rd_addr_b (addr_b),
      .rd_data_b (rdata_b)
   );

endmodule

FILE: sv/ising_metropolis_update.sv
// Metropolis update engine for a 64 x 64 Ising lattice with periodic edges. The controller
// handles one item at a time and accepts each item in its idle state, so a new item is only
// taken once the last one has left its INIT or EVAL state. An init item then goes to INIT,
// where its result is loaded; an update item goes through RD_A, RD_B and RD_C to EVAL, where
// its result is loaded: the lattice RAM has two read ports, so the center and four neighbors
// are read across the read states, and EVAL decides the flip and writes back. A finished
// result waits in an output register, so the next item is taken while it is still pending;
// that item's final cycle then stalls until the register drains. The lattice has no reset;
// every site must be initialized before an update touches it or any of its neighbors.
module ising_metropolis_update
   import ising_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,   // row, col, random_fraction, zero pad
   input  logic             req_tuser,   // kind
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [63:0]      rsp_tdata,   // spin_after, flipped, magnetization, magnetization_sum
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0] csr_data
);

   dp_cmd_type cmd;

   ising_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ising_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

FILE: sv/ising_checker.sv
module ising_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // A stalled result holds its item
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // One item in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while busy");

   // An update attempt keeps the input blocked through its read and decide states
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=>
         !req_tready ##1 !req_tready ##1 !req_tready ##1 !req_tready)
      else $error("update finished too early");

   // A new result appears only right after a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result without work");

endmodule

bind ising_metropolis_update ising_checker u_checker (.*);
